[design/assert_macros.svh]
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[design/i2cseq_pkg.sv]
package i2cseq_pkg;

  // EEPROM page size in bytes; must be a power of two.
  localparam int PAGE_BYTES = 64;
  localparam int PAGE_W     = $clog2(PAGE_BYTES);

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int DEV_W  = 7;
  localparam int KIND_W = 3;
  localparam int STEP_W = 4;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [DEV_W-1:0] DEVICE_SELECT_RESET = 7'd80;

  // Read/write bit appended to the control byte.
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  // Input command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    SYM_START   = 3'd0,
    SYM_SEND    = 3'd1,
    SYM_RX_ACK  = 3'd2,
    SYM_RX_NACK = 3'd3,
    SYM_STOP    = 3'd4,
    SYM_WAIT    = 3'd5
  } sym_kind_t;

  // Symbols that precede the data symbol of one byte.
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_WR_HDR,
    PRE_RD_HDR,
    PRE_PAGE
  } prefix_t;

  // One classified byte, handed from the front to the back.
  typedef struct packed {
    prefix_t            prefix;
    logic               is_read;
    logic               last;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
  } job_t;

  // Status of the queue seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/i2cseq_front.sv]
`include "assert_macros.svh"

module i2cseq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic                           first_byte,
  input  logic                           last_byte,
  input  logic [i2cseq_pkg::ADDR_W-1:0]  start_address,
  input  logic [i2cseq_pkg::DATA_W-1:0]  write_data,
  input  i2cseq_pkg::queue_status_t      q_status,
  output logic                           push,
  output i2cseq_pkg::job_t               push_job
);
  import i2cseq_pkg::*;

  logic [ADDR_W-1:0] current_address;
  logic              transfer_open;
  logic              open_is_read;

  logic              begin_xfer;
  logic [ADDR_W-1:0] base_addr;
  logic              page_start;

  // A byte is taken whenever the queue has room.
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // Classify the byte: new transfer, page break, or plain continuation.
  always_comb begin
    begin_xfer = first_byte || !transfer_open || (open_is_read != command);
    base_addr  = first_byte ? start_address : current_address;
    page_start = (current_address[PAGE_W-1:0] == '0);

    push_job.is_read = command;
    push_job.last    = last_byte;
    push_job.addr    = base_addr;
    push_job.data    = write_data;
    if (begin_xfer) begin
      push_job.prefix = (command == CMD_READ) ? PRE_RD_HDR : PRE_WR_HDR;
    end else if ((command == CMD_WRITE) && page_start) begin
      push_job.prefix = PRE_PAGE;
    end else begin
      push_job.prefix = PRE_NONE;
    end
  end

  // Transfer state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_address <= '0;
      transfer_open   <= 1'b0;
      open_is_read    <= 1'b0;
    end else if (push) begin
      current_address <= base_addr + ADDR_W'(1);
      transfer_open   <= !last_byte;
      open_is_read    <= command;
    end
  end

  `ASSERT_NEXT(a_open_after_middle, clk, rst, push && !last_byte, transfer_open)
  `ASSERT_NEXT(a_addr_step, clk, rst, push && !first_byte,
               current_address == $past(current_address) + ADDR_W'(1))

endmodule

[design/i2cseq_queue.sv]
`include "assert_macros.svh"

module i2cseq_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  i2cseq_pkg::job_t           push_job,
  input  logic                       pop,
  output i2cseq_pkg::job_t           head_job,
  output i2cseq_pkg::queue_status_t  q_status
);
  import i2cseq_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_job       = entries[rd_ptr];
  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `ASSERT_SAME(a_no_push_full, clk, rst, q_status.full, !push)
  `ASSERT_SAME(a_no_pop_empty, clk, rst, q_status.empty, !pop)

endmodule

[design/i2cseq_back.sv]
`include "assert_macros.svh"

module i2cseq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [i2cseq_pkg::DEV_W-1:0]  device_select,
  input  i2cseq_pkg::job_t              head_job,
  input  i2cseq_pkg::queue_status_t     q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i2cseq_pkg::KIND_W-1:0] symbol_kind,
  output logic [i2cseq_pkg::DATA_W-1:0] symbol_byte,
  output logic                          end_of_run
);
  import i2cseq_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] prefix_len;
  logic [STEP_W-1:0] run_len;
  logic [STEP_W-1:0] hdr_idx;
  logic [STEP_W-1:0] tail_idx;
  logic              load;
  logic              last_step;
  sym_kind_t         kind_next;
  logic [DATA_W-1:0] byte_next;

  // A symbol is loaded when the head has work and the output slot frees.
  assign load      = !q_status.empty && (!out_valid || out_ready);
  assign last_step = (step == run_len - STEP_W'(1));
  assign pop       = load && last_step;

  // Length of the symbol run for the byte at the head of the queue.
  always_comb begin
    unique case (head_job.prefix)
      PRE_NONE:   prefix_len = STEP_W'(0);
      PRE_WR_HDR: prefix_len = STEP_W'(4);
      PRE_RD_HDR: prefix_len = STEP_W'(6);
      PRE_PAGE:   prefix_len = STEP_W'(6);
      default:    prefix_len = STEP_W'(0);
    endcase
    if (head_job.is_read) begin
      run_len = prefix_len + (head_job.last ? STEP_W'(2) : STEP_W'(1));
    end else begin
      run_len = prefix_len + (head_job.last ? STEP_W'(3) : STEP_W'(1));
    end
  end

  // Symbol selected by the current step.
  always_comb begin
    hdr_idx   = (head_job.prefix == PRE_PAGE) ? step - STEP_W'(2) : step;
    tail_idx  = step - prefix_len;
    kind_next = SYM_START;
    byte_next = '0;
    if (step < prefix_len) begin
      if ((head_job.prefix == PRE_PAGE) && (step == STEP_W'(0))) begin
        kind_next = SYM_STOP;
      end else if ((head_job.prefix == PRE_PAGE) && (step == STEP_W'(1))) begin
        kind_next = SYM_WAIT;
      end else begin
        unique case (hdr_idx)
          STEP_W'(1): begin
            kind_next = SYM_SEND;
            byte_next = {device_select, RW_WRITE};
          end
          STEP_W'(2): begin
            kind_next = SYM_SEND;
            byte_next = head_job.addr[ADDR_W-1:DATA_W];
          end
          STEP_W'(3): begin
            kind_next = SYM_SEND;
            byte_next = head_job.addr[DATA_W-1:0];
          end
          STEP_W'(5): begin
            kind_next = SYM_SEND;
            byte_next = {device_select, RW_READ};
          end
          default: kind_next = SYM_START;
        endcase
      end
    end else if (head_job.is_read) begin
      if (tail_idx == STEP_W'(0)) begin
        kind_next = head_job.last ? SYM_RX_NACK : SYM_RX_ACK;
      end else begin
        kind_next = SYM_STOP;
      end
    end else begin
      if (tail_idx == STEP_W'(0)) begin
        kind_next = SYM_SEND;
        byte_next = head_job.data;
      end else if (tail_idx == STEP_W'(1)) begin
        kind_next = SYM_STOP;
      end else begin
        kind_next = SYM_WAIT;
      end
    end
  end

  // Step counter and control of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= last_step ? '0 : step + STEP_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      symbol_kind <= kind_next;
      symbol_byte <= byte_next;
      end_of_run  <= last_step;
    end
  end

  `ASSERT_SAME(a_step_in_run, clk, rst, !q_status.empty, step < run_len)
  `ASSERT_NEXT(a_step_restart, clk, rst, pop, step == '0)

endmodule

[design/i2c_eeprom_transfer_sequencer.sv]
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    command, first_byte, last_byte,
//                                             start_address, write_data
// out       output     out_valid / out_ready  symbol_kind, symbol_byte, end_of_run
// cfg       input      cfg_valid / cfg_ready  cfg_data (device_select)
//
// Each input byte produces one to nine bus symbols, one symbol per cycle unless
// the output stalls, set by the back sequencer stepping through the run of the
// byte at the queue head. A byte is accepted whenever the four-entry queue has room.
// Reset is synchronous and active high; it clears the transfer state and the queue.
// A stalled output holds its symbol; the front keeps filling the queue meanwhile.
module i2c_eeprom_transfer_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i2cseq_pkg::DEV_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic                           first_byte,
  input  logic                           last_byte,
  input  logic [i2cseq_pkg::ADDR_W-1:0]  start_address,
  input  logic [i2cseq_pkg::DATA_W-1:0]  write_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [i2cseq_pkg::KIND_W-1:0]  symbol_kind,
  output logic [i2cseq_pkg::DATA_W-1:0]  symbol_byte,
  output logic                           end_of_run
);
  import i2cseq_pkg::*;

  logic [DEV_W-1:0] device_select;
  logic             push;
  job_t             push_job;
  logic             pop;
  job_t             head_job;
  queue_status_t    q_status;

  // The device register takes every configuration transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_select <= DEVICE_SELECT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      device_select <= cfg_data;
    end
  end

  i2cseq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .start_address (start_address),
    .write_data    (write_data),
    .q_status      (q_status),
    .push          (push),
    .push_job      (push_job)
  );

  i2cseq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  i2cseq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .device_select (device_select),
    .head_job      (head_job),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .symbol_kind   (symbol_kind),
    .symbol_byte   (symbol_byte),
    .end_of_run    (end_of_run)
  );

endmodule
